>>> rtl/core/swtt_pkg.sv
// shared types, constants and controller/datapath interface of the software timer table
package swtt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TIME_W     = 40;
  localparam int MS_W       = 24;
  localparam int ID_W       = 16;
  localparam int LSN_W      = 16;
  localparam int POLL_W     = 16;
  localparam int TMO_W      = 25;
  localparam int RES_MAX    = 16;
  localparam int CNT_W      = $clog2(RES_MAX + 1);

  localparam logic [POLL_W-1:0] IDLE_POLL_RESET = POLL_W'(1000);
  localparam logic [TMO_W-1:0]  TIMEOUT_NONE    = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TICK   = 2'd2,
    OP_LISTEN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_IDLE_TICK = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic add;
    logic clear;
    logic listen;
    logic time_inc;
    logic due_capture;
    logic fire;
    logic none;
    logic scan_clear;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fire_pending;
    logic scan_last;
    logic out_done;
  } sts_t;

endpackage

>>> rtl/core/software_timer_table_unit.sv
// top level of the software timer table: stream ports, controller and datapath
// Table of NUM_TIMERS (16) one-shot or periodic millisecond timers. Each request on the
// slave stream is one operation: add (first free slot, fresh nonzero id, or table_full),
// clear (drops every active slot holding target_id), tick (time advances one millisecond,
// then each due slot fires in slot order, periodic ones re-armed at now plus period) or
// listen (counts one listener, saturating). Every result carries the least remaining time
// over active slots, else idle_poll_ms when listeners exist, else -1, plus has_work;
// tlast marks the final result of a request. One request is handled at a time: add,
// clear, listen and each fired timer of a tick (or its idle result when none fires) are
// each followed by the one-slot-per-cycle next-timeout scan, and each result waits out
// any output stall. idle_poll_ms is written at any time through the cfg channel,
// which is always ready.
module software_timer_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // first_expiry[23:0], period_ms[47:24], target_id[63:48]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // timer_handle[15:0], table_full[16], next_timeout_ms[41:17], has_work[42], zero fill
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data       // idle_poll_ms
);
  import swtt_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  op_t               in_op;
  kind_t             out_kind;
  logic [ID_W-1:0]   out_handle;
  logic              out_full;
  logic [TMO_W-1:0]  out_timeout;
  logic              out_has_work;

  // operation code straight from the request sideband
  assign in_op     = op_t'(s_axis_tuser);
  assign cfg_ready = 1'b1;

  swtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (in_op),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swtt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_delay     (s_axis_tdata[23:0]),
    .in_period    (s_axis_tdata[47:24]),
    .in_target    (s_axis_tdata[63:48]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (out_kind),
    .out_handle   (out_handle),
    .out_full     (out_full),
    .out_timeout  (out_timeout),
    .out_has_work (out_has_work),
    .out_last     (m_axis_tlast)
  );

  // result packing, low field first
  assign m_axis_tdata = {5'd0, out_has_work, out_timeout, out_full, out_handle};
  assign m_axis_tuser = out_kind;

  // no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while a result is pending");

  // a taken request closes the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken back to back");

  // nothing pending means the timeout reads as none
  a_idle_timeout: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[42]) |-> (m_axis_tdata[41:17] == TIMEOUT_NONE))
    else $error("timeout set with no work pending");

  // fired timers always carry a real id
  a_fired_handle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_FIRED)) |-> (m_axis_tdata[15:0] != '0))
    else $error("fired result with zero handle");

endmodule

>>> rtl/core/swtt_ctrl.sv
// sequencing state machine of the software timer table
module swtt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  swtt_pkg::op_t     in_op,
  output logic              in_ready,
  output swtt_pkg::cmd_t    cmd,
  input  swtt_pkg::sts_t    sts
);
  import swtt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_CLEAR, S_LISTEN, S_TICK, S_DUE, S_CHECK,
    S_FIRE, S_NONE, S_SCAN, S_LOAD, S_WAIT
  } state_t;

  state_t state;
  logic   tick_item;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load_item = in_valid;
      S_ADD:    begin cmd.add = 1'b1;    cmd.scan_clear = 1'b1; end
      S_CLEAR:  begin cmd.clear = 1'b1;  cmd.scan_clear = 1'b1; end
      S_LISTEN: begin cmd.listen = 1'b1; cmd.scan_clear = 1'b1; end
      S_TICK:   cmd.time_inc = 1'b1;
      S_DUE:    cmd.due_capture = 1'b1;
      S_CHECK:  ;
      S_FIRE:   begin cmd.fire = 1'b1;   cmd.scan_clear = 1'b1; end
      S_NONE:   begin cmd.none = 1'b1;   cmd.scan_clear = 1'b1; end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_LOAD:   cmd.load_out = 1'b1;
      S_WAIT:   ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick_item <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tick_item <= (in_op == OP_TICK);
            unique case (in_op)
              OP_ADD:    state <= S_ADD;
              OP_CLEAR:  state <= S_CLEAR;
              OP_TICK:   state <= S_TICK;
              OP_LISTEN: state <= S_LISTEN;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_ADD, S_CLEAR, S_LISTEN, S_FIRE, S_NONE: state <= S_SCAN;
        S_TICK:  state <= S_DUE;
        S_DUE:   state <= S_CHECK;
        S_CHECK: state <= sts.fire_pending ? S_FIRE : S_NONE;
        S_SCAN:  if (sts.scan_last) state <= S_LOAD;
        S_LOAD:  state <= S_WAIT;
        S_WAIT: begin
          if (sts.out_done) begin
            state <= (tick_item && sts.fire_pending) ? S_FIRE : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/swtt_datapath.sv
// slot registers, time base, next-timeout scan and result register
module swtt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  swtt_pkg::cmd_t                cmd,
  output swtt_pkg::sts_t                sts,
  input  swtt_pkg::op_t                 in_op,
  input  logic [swtt_pkg::MS_W-1:0]     in_delay,
  input  logic [swtt_pkg::MS_W-1:0]     in_period,
  input  logic [swtt_pkg::ID_W-1:0]     in_target,
  input  logic                          cfg_valid,
  input  logic [swtt_pkg::POLL_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swtt_pkg::kind_t               out_kind,
  output logic [swtt_pkg::ID_W-1:0]     out_handle,
  output logic                          out_full,
  output logic [swtt_pkg::TMO_W-1:0]    out_timeout,
  output logic                          out_has_work,
  output logic                          out_last
);
  import swtt_pkg::*;

  logic [NUM_TIMERS-1:0] active;
  logic [ID_W-1:0]       slot_id     [NUM_TIMERS];
  logic [TIME_W-1:0]     slot_due    [NUM_TIMERS];
  logic [MS_W-1:0]       slot_period [NUM_TIMERS];

  logic [TIME_W-1:0] time_now;
  logic [ID_W-1:0]   id_counter;
  logic [LSN_W-1:0]  listeners;
  logic [POLL_W-1:0] idle_poll;

  op_t             op;
  logic [MS_W-1:0] delay;
  logic [MS_W-1:0] period;
  logic [ID_W-1:0] target;

  logic [NUM_TIMERS-1:0] due_vec;
  logic [CNT_W-1:0]      fire_cnt;

  kind_t           res_kind;
  logic [ID_W-1:0] res_handle;
  logic            res_full;

  logic [SLOT_W-1:0] scan_idx;
  logic              found;
  logic [MS_W-1:0]   best;

  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] fire_idx;
  logic              fire_pending;
  logic [TIME_W-1:0] diff;
  logic [MS_W-1:0]   rem;

  // lowest inactive slot and lowest due slot
  always_comb begin
    free_idx = '0;
    fire_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active[i]) free_idx = SLOT_W'(i);
      if (due_vec[i]) fire_idx = SLOT_W'(i);
    end
  end

  assign fire_pending = (|due_vec) && (fire_cnt < CNT_W'(RES_MAX));

  // remaining time of the scanned slot, floored at zero, capped at 24 bits
  always_comb begin
    diff = slot_due[scan_idx] - time_now;
    if (slot_due[scan_idx] <= time_now) begin
      rem = '0;
    end else if (|diff[TIME_W-1:MS_W]) begin
      rem = '1;
    end else begin
      rem = diff[MS_W-1:0];
    end
  end

  assign sts.fire_pending = fire_pending;
  assign sts.scan_last    = (scan_idx == SLOT_W'(NUM_TIMERS - 1));
  assign sts.out_done     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      time_now   <= '0;
      id_counter <= ID_W'(1);
      listeners  <= '0;
      idle_poll  <= IDLE_POLL_RESET;
      out_valid  <= 1'b0;
      due_vec    <= '0;
      fire_cnt   <= '0;
    end else begin
      if (cfg_valid) idle_poll <= cfg_data;

      if (cmd.load_item) begin
        op     <= in_op;
        delay  <= in_delay;
        period <= in_period;
        target <= in_target;
      end

      if (cmd.add) begin
        res_kind   <= KIND_ACK;
        res_full   <= &active;
        res_handle <= (&active) ? '0 : id_counter;
        if (!(&active)) begin
          active[free_idx]      <= 1'b1;
          slot_id[free_idx]     <= id_counter;
          slot_due[free_idx]    <= time_now + TIME_W'(delay);
          slot_period[free_idx] <= period;
          id_counter <= (&id_counter) ? ID_W'(1) : id_counter + ID_W'(1);
        end
      end

      if (cmd.clear) begin
        res_kind   <= KIND_ACK;
        res_full   <= 1'b0;
        res_handle <= '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (slot_id[i] == target) active[i] <= 1'b0;
        end
      end

      if (cmd.listen) begin
        res_kind   <= KIND_ACK;
        res_full   <= 1'b0;
        res_handle <= '0;
        if (!(&listeners)) listeners <= listeners + LSN_W'(1);
      end

      if (cmd.time_inc) begin
        time_now <= time_now + TIME_W'(1);
        fire_cnt <= '0;
      end

      if (cmd.due_capture) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          due_vec[i] <= active[i] && (slot_due[i] <= time_now);
        end
      end

      if (cmd.fire) begin
        res_kind   <= KIND_FIRED;
        res_full   <= 1'b0;
        res_handle <= slot_id[fire_idx];
        due_vec[fire_idx] <= 1'b0;
        fire_cnt <= fire_cnt + CNT_W'(1);
        if (|slot_period[fire_idx]) begin
          slot_due[fire_idx] <= time_now + TIME_W'(slot_period[fire_idx]);
        end else begin
          active[fire_idx] <= 1'b0;
        end
      end

      if (cmd.none) begin
        res_kind   <= KIND_IDLE_TICK;
        res_full   <= 1'b0;
        res_handle <= '0;
      end

      if (cmd.scan_clear) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + SLOT_W'(1);
        if (active[scan_idx] && (!found || rem < best)) begin
          best  <= rem;
          found <= 1'b1;
        end
      end

      if (cmd.load_out) begin
        out_valid    <= 1'b1;
        out_kind     <= res_kind;
        out_handle   <= res_handle;
        out_full     <= res_full;
        out_has_work <= (|listeners) || (|active);
        out_last     <= (op == OP_TICK) ? !fire_pending : 1'b1;
        if (found) begin
          out_timeout <= TMO_W'(best);
        end else if (|listeners) begin
          out_timeout <= TMO_W'(idle_poll);
        end else begin
          out_timeout <= TIMEOUT_NONE;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> test/software_timer_table_unit_tb.sv
// self-checking testbench for the software timer table unit
`timescale 1ns / 100ps

module software_timer_table_unit_tb;
  import swtt_pkg::*;

  // one expected result on the master stream
  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  handle;
    logic             full;
    logic [TMO_W-1:0] timeout;
    logic             work;
    logic             last;
  } timer_result_t;

  // shadow copy of the timer table; predicts every result of each accepted request
  class timer_table_scoreboard;
    bit               active [NUM_TIMERS];
    bit [ID_W-1:0]    ids    [NUM_TIMERS];
    bit [TIME_W-1:0]  due    [NUM_TIMERS];
    bit [MS_W-1:0]    period [NUM_TIMERS];
    bit [TIME_W-1:0]  now_ms;
    bit [ID_W-1:0]    next_id;
    bit [LSN_W-1:0]   listeners;
    bit [POLL_W-1:0]  idle_poll;
    timer_result_t    pending[$];
    int               errors;

    function new();
      foreach (active[i]) active[i] = 0;
      now_ms    = '0;
      next_id   = 1;
      listeners = '0;
      idle_poll = IDLE_POLL_RESET;
      errors    = 0;
    endfunction

    function bit busy();
      busy = listeners != 0;
      foreach (active[i]) if (active[i]) busy = 1;
    endfunction

    // least remaining time over active slots, else idle poll, else none
    function logic [TMO_W-1:0] least_remaining();
      bit              found;
      bit [TIME_W-1:0] rem;
      bit [TIME_W-1:0] best;
      found = 0;
      best  = '0;
      foreach (active[i]) begin
        if (!active[i]) continue;
        rem = (due[i] > now_ms) ? due[i] - now_ms : '0;
        if (rem > 40'hFF_FFFF) rem = 40'hFF_FFFF;
        if (!found || rem < best) begin
          best  = rem;
          found = 1;
        end
      end
      if (found) return TMO_W'(best);
      if (listeners != 0) return TMO_W'(idle_poll);
      return TIMEOUT_NONE;
    endfunction

    function void push_result(kind_t k, logic [ID_W-1:0] h, logic f);
      timer_result_t r;
      r.kind    = k;
      r.handle  = h;
      r.full    = f;
      r.timeout = least_remaining();
      r.work    = busy();
      r.last    = 0;
      pending.push_back(r);
    endfunction

    function void note_request(op_t op, logic [MS_W-1:0] d, logic [MS_W-1:0] p,
                               logic [ID_W-1:0] target);
      int free_slot;
      int n;
      free_slot = -1;
      n = pending.size();
      case (op)
        OP_ADD: begin
          foreach (active[i]) if (!active[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            push_result(KIND_ACK, '0, 1'b1);
          end else begin
            active[free_slot] = 1;
            ids[free_slot]    = next_id;
            due[free_slot]    = now_ms + TIME_W'(d);
            period[free_slot] = p;
            next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
            push_result(KIND_ACK, ids[free_slot], 1'b0);
          end
        end
        OP_CLEAR: begin
          foreach (active[i]) if (active[i] && ids[i] == target) active[i] = 0;
          push_result(KIND_ACK, '0, 1'b0);
        end
        OP_LISTEN: begin
          if (listeners != 16'hFFFF) listeners++;
          push_result(KIND_ACK, '0, 1'b0);
        end
        default: begin
          now_ms++;
          // slot order, due time reached means not above the current time
          foreach (active[i]) begin
            if (!active[i] || due[i] > now_ms) continue;
            if (period[i] != 0) due[i] = now_ms + TIME_W'(period[i]);
            else active[i] = 0;
            push_result(KIND_FIRED, ids[i], 1'b0);
          end
          if (pending.size() == n) push_result(KIND_IDLE_TICK, '0, 1'b0);
        end
      endcase
      pending[pending.size()-1].last = 1;
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d handle %0d", got.kind, got.handle);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp kind %0d id %0d full %0b tmo %h work %0b last %0b",
                    " / got kind %0d id %0d full %0b tmo %h work %0b last %0b"},
                   want.kind, want.handle, want.full, want.timeout, want.work, want.last,
                   got.kind, got.handle, got.full, got.timeout, got.work, got.last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // first_expiry[23:0], period_ms[47:24], target_id[63:48]
  logic [1:0]  s_axis_tuser = '0;  // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;  // timer_handle, table_full, next_timeout_ms, has_work
  logic [1:0]  m_axis_tuser;  // kind[1:0]
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  timer_table_scoreboard timers = new();
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int quiet_cycles    = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  software_timer_table_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random back-pressure, drawn at the falling edge
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // result monitor and watchdog, both on the rising edge
  always @(posedge clk) begin
    timer_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = kind_t'(m_axis_tuser);
      got.handle  = m_axis_tdata[15:0];
      got.full    = m_axis_tdata[16];
      got.timeout = m_axis_tdata[41:17];
      got.work    = m_axis_tdata[42];
      got.last    = m_axis_tlast;
      timers.check_result(got);
    end
    if (rst || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
        || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request on the slave stream, with optional idle cycles ahead of it
  task automatic send_request(op_t op, logic [MS_W-1:0] d, logic [MS_W-1:0] p,
                              logic [ID_W-1:0] target);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = op;
    s_axis_tdata  = {target, p, d};
    do @(posedge clk); while (!s_axis_tready);
    timers.note_request(op, d, p, target);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  // waits for every expected result, then for any trailing scan to finish
  task automatic drain();
    while (timers.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_idle_poll(logic [15:0] value);
    drain();
    cfg_valid = 1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    timers.idle_poll = value;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_request();
    int              pick;
    logic [MS_W-1:0] d;
    logic [MS_W-1:0] p;
    logic [ID_W-1:0] target;
    pick = $urandom_range(0, 99);
    // mostly short timers so that ticks actually fire them
    d = ($urandom_range(0, 7) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 30));
    p = ($urandom_range(0, 2) == 0) ? '0 : MS_W'($urandom_range(1, 40));
    if ($urandom_range(0, 9) == 0) p = MS_W'($urandom);
    target = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                         : timers.ids[$urandom_range(0, NUM_TIMERS-1)];
    if (pick < 45)      send_request(OP_TICK, d, p, target);
    else if (pick < 75) send_request(OP_ADD, d, p, target);
    else if (pick < 90) send_request(OP_CLEAR, d, p, target);
    else                send_request(OP_LISTEN, d, p, target);
  endtask

  initial begin
    logic [15:0] poll_values [4];
    poll_values = '{16'd0, 16'hFFFF, 16'd0, 16'd1000};
    poll_values[2] = 16'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty table, extremes, unknown clear, periodic re-arm, table full
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, 16'hFFFF);
    send_request(OP_LISTEN, '1, '1, '1);
    send_request(OP_ADD, '0, '0, '0);
    send_request(OP_ADD, 24'hFF_FFFF, 24'hFF_FFFF, '0);
    send_request(OP_ADD, 24'd2, 24'd3, '0);
    repeat (5) send_request(OP_TICK, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, 16'd3);
    for (int i = 0; i < 16; i++) send_request(OP_ADD, 24'd5, '0, '0);
    // all one-shots now due together on a single tick
    repeat (5) send_request(OP_TICK, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, 16'd2);

    // random phases: each idle poll setting under each idling pattern
    foreach (poll_values[v]) begin
      write_idle_poll(poll_values[v]);
      for (int ph = 0; ph < 4; ph++) begin
        sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 56 : 13) : 0;
        recv_stall_pct  = (ph == 2 || ph == 3) ? ((ph == 2) ? 56 : 13) : 0;
        repeat (26) random_request();
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    drain();
    if (timers.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/swtt_pkg.sv
rtl/core/swtt_ctrl.sv
rtl/core/swtt_datapath.sv
rtl/core/software_timer_table_unit.sv
test/software_timer_table_unit_tb.sv
